>>> rtl/bldc_pkg.sv
// ----------------------------------------------------------------------------
// bldc_pkg
// Shared types and constants for the six-step speed controller.
// ----------------------------------------------------------------------------
`default_nettype none

package bldc_pkg;

  localparam int unsigned DivSteps = 24;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  localparam logic [23:0] SpeedNum   = 24'd10_000_000;
  localparam logic [31:0] DutyDiv    = 32'd125;
  localparam logic [15:0] DutyMinQ16 = 16'd3277;
  localparam logic [15:0] DutyMaxQ16 = 16'd62259;
  localparam logic signed [48:0] VHigh = 49'sd1900;
  localparam logic signed [48:0] VLow  = 49'sd100;
  localparam logic signed [47:0] SumMax = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] SumMin = {1'b1, {47{1'b0}}};

  localparam logic [1:0] PhA = 2'd0;
  localparam logic [1:0] PhB = 2'd1;
  localparam logic [1:0] PhC = 2'd2;

  localparam logic CmdEdge = 1'b0;
  localparam logic CmdStep = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RPM,
    ST_ERR,
    ST_ACC,
    ST_MIX,
    ST_CLAMP,
    ST_DUTY,
    ST_OUT
  } ctl_state_e;

  typedef struct packed {
    logic        start;
    logic [23:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] hi;
    logic [1:0] lo;
    logic [1:0] fl;
  } phase_set_t;

  function automatic phase_set_t sector_phases(input logic [2:0] sector);
    phase_set_t p;
    p = '0;
    unique case (sector)
      3'd0: p = '{1'b1, PhA, PhB, PhC};
      3'd1: p = '{1'b1, PhA, PhC, PhB};
      3'd2: p = '{1'b1, PhB, PhC, PhA};
      3'd3: p = '{1'b1, PhB, PhA, PhC};
      3'd4: p = '{1'b1, PhC, PhA, PhB};
      3'd5: p = '{1'b1, PhC, PhB, PhA};
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

>>> rtl/bldc_div.sv
// ----------------------------------------------------------------------------
// bldc_div
// Bit-serial restoring divider, 24-bit dividend by 32-bit divisor,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bldc_div
  import bldc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire div_req_t    req_i,
  output logic             done_o,
  output logic [23:0]      quot_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [31:0]        rem_q, rem_d;
  logic [31:0]        dvs_q, dvs_d;
  logic [23:0]        sh_q, sh_d;
  logic [32:0]        trial;
  logic [32:0]        diff;
  logic               qbit;

  always_comb begin
    trial = {rem_q, sh_q[23]};
    diff  = trial - {1'b0, dvs_q};
    qbit  = (trial >= {1'b0, dvs_q});
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    sh_d   = sh_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      sh_d   = req_i.dividend;
    end else if (busy_q) begin
      rem_d = qbit ? diff[31:0] : trial[31:0];
      sh_d  = {sh_q[22:0], qbit};
      cnt_d = cnt_q + DivCntW'(1);
      if (cnt_q == DivCntW'(DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    sh_q  <= sh_d;
  end

  assign done_o = done_q;
  assign quot_o = sh_q;

endmodule

`default_nettype wire

>>> rtl/bldc_six_step_speed_controller_top.sv
// ----------------------------------------------------------------------------
// bldc_six_step_speed_controller_top
// Hall edge period capture, serial speed measurement, PI duty and six-step
// commutation phase selection.
// ----------------------------------------------------------------------------
//  channel  dir  handshake               payload
//  in       in   in_valid_i / in_stall_o  cmd_i, timestamp_us_i, sector_i
//  out      out  out_valid_o / out_stall_i drive_valid_o .. speed_rpm_o
//  cfg      in   cfg_valid_i / cfg_ready_o target_rpm_i
//
//  Edge events only update the period. A control step runs the speed divide
//  and, when the duty does not clamp, the duty scaling divide, both in the
//  shared bit-serial divider. Zero period skips the speed divide. Reset
//  clears FSM state, target, timestamp, period, integrator and out_valid_o.
//  One result waits in the output register under out_stall_i while new items
//  are taken; a step holds in its last state until that register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module bldc_six_step_speed_controller_top
  import bldc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        cmd_i,
  input  wire logic [31:0] timestamp_us_i,
  input  wire logic [2:0]  sector_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             drive_valid_o,
  output logic [1:0]       high_phase_o,
  output logic [1:0]       low_phase_o,
  output logic [1:0]       float_phase_o,
  output logic [15:0]      duty_q16_o,
  output logic [23:0]      speed_rpm_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [19:0] target_rpm_i
);

  ctl_state_e state_q, state_d;

  logic [19:0]        target_q;
  logic [31:0]        last_q;
  logic [31:0]        period_q;
  logic signed [47:0] sum_q, sum_d;
  logic [2:0]         sector_q;
  logic [23:0]        rpm_q;
  logic signed [24:0] err_q;
  logic signed [32:0] prod_q;
  logic signed [48:0] v_q;
  logic [15:0]        duty_q;
  logic signed [48:0] sum_wide;

  logic       out_valid_q;
  logic       drive_valid_q;
  logic [1:0] high_q, low_q, float_q;
  logic [15:0] duty_out_q;
  logic [23:0] rpm_out_q;

  logic       in_xfer;
  logic       out_xfer;
  logic       out_free;
  logic       out_load;
  div_req_t   div_req;
  logic       div_done;
  logic [23:0] div_quot;
  phase_set_t ph;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_q && !out_stall_i;
  assign out_free = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  bldc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer && (cmd_i == CmdStep)) begin
          state_d = (period_q == '0) ? ST_ERR : ST_RPM;
        end
      end
      ST_RPM: begin
        if (div_done) state_d = ST_ERR;
      end
      ST_ERR:   state_d = ST_ACC;
      ST_ACC:   state_d = ST_MIX;
      ST_MIX:   state_d = ST_CLAMP;
      ST_CLAMP: begin
        if (v_q >= VHigh || v_q <= VLow) state_d = ST_OUT;
        else                             state_d = ST_DUTY;
      end
      ST_DUTY: begin
        if (div_done) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall_o = 1'b1;
    out_load   = 1'b0;
    div_req    = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o       = 1'b0;
        div_req.start    = in_valid_i && (cmd_i == CmdStep) && (period_q != '0);
        div_req.dividend = SpeedNum;
        div_req.divisor  = period_q;
      end
      ST_CLAMP: begin
        div_req.start    = !(v_q >= VHigh || v_q <= VLow);
        div_req.dividend = 24'({v_q[10:0], 12'b0});
        div_req.divisor  = DutyDiv;
      end
      ST_OUT: out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    sum_wide = 49'(sum_q) + 49'(err_q);
    if (sum_wide[48] != sum_wide[47]) sum_d = sum_wide[48] ? SumMin : SumMax;
    else                              sum_d = sum_wide[47:0];
  end

  assign ph = sector_phases(sector_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      target_q    <= '0;
      last_q      <= '0;
      period_q    <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) target_q <= target_rpm_i;
      if (in_xfer && (cmd_i == CmdEdge)) begin
        period_q <= timestamp_us_i - last_q;
        last_q   <= timestamp_us_i;
      end
      if (state_q == ST_ACC) sum_q <= sum_d;
      if (out_load)      out_valid_q <= 1'b1;
      else if (out_xfer) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && (cmd_i == CmdStep)) begin
      sector_q <= sector_i;
      rpm_q    <= '0;
    end
    if (state_q == ST_RPM && div_done) rpm_q <= div_quot;
    if (state_q == ST_ERR) begin
      err_q <= $signed({5'b0, target_q}) - $signed({1'b0, rpm_q});
    end
    if (state_q == ST_ACC) prod_q <= 33'(err_q) * 33'sd200;
    if (state_q == ST_MIX) v_q <= 49'(prod_q) + 49'(sum_q);
    if (state_q == ST_CLAMP) begin
      if (v_q >= VHigh)     duty_q <= DutyMaxQ16;
      else if (v_q <= VLow) duty_q <= DutyMinQ16;
    end
    if (state_q == ST_DUTY && div_done) duty_q <= div_quot[15:0];
    if (out_load) begin
      drive_valid_q <= ph.valid;
      high_q        <= ph.hi;
      low_q         <= ph.lo;
      float_q       <= ph.fl;
      duty_out_q    <= duty_q;
      rpm_out_q     <= rpm_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign drive_valid_o = drive_valid_q;
  assign high_phase_o  = high_q;
  assign low_phase_o   = low_q;
  assign float_phase_o = float_q;
  assign duty_q16_o    = duty_out_q;
  assign speed_rpm_o   = rpm_out_q;

endmodule

`default_nettype wire
